### design/pls_pkg.sv
// Shared types and codes for the positional list store.
package pls_pkg;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_MODIFY = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    // Operation broadcast to every cell of the row
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_WRITE  = 2'd2,
        CELL_REMOVE = 2'd3
    } t_cell_op;

    localparam int POS_BITS    = 6;
    localparam int WORD_BITS   = 32;
    localparam int LEN_OUT_BITS = 7;

    typedef struct packed {
        t_cmd                        command;
        logic [POS_BITS-1:0]         position;
        logic                        at_end;
        logic signed [WORD_BITS-1:0] value;
    } t_in_item;

    typedef struct packed {
        t_status                     status;
        logic signed [WORD_BITS-1:0] read_value;
        logic [LEN_OUT_BITS-1:0]     list_length;
    } t_out_item;

endpackage

### design/pls_cell.sv
// One list slot: holds an entry and trades it with its neighbors on insert and remove.
module pls_cell
    import pls_pkg::*;
#(
    parameter int INDEX      = 0,
    parameter int LEN_W      = 7,
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell_op              i_op,
    input  logic [LEN_W-1:0]      i_pos,
    input  logic [LEN_W-1:0]      i_len,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic [VALUE_BITS-1:0] i_left,
    input  logic [VALUE_BITS-1:0] i_right,
    output logic [VALUE_BITS-1:0] o_entry
);

    localparam logic [LEN_W-1:0] IDX = LEN_W'(INDEX);

    logic [VALUE_BITS-1:0] r_entry;
    logic [VALUE_BITS-1:0] n_entry;
    logic [LEN_W-1:0]      w_last;

    assign w_last = i_len - LEN_W'(1);

    always_comb begin
        n_entry = r_entry;
        case (i_op)
            CELL_INSERT: begin
                if (IDX == i_pos) begin
                    n_entry = i_value;
                end else if (IDX > i_pos && IDX <= i_len) begin
                    n_entry = i_left;
                end else if (IDX >= i_len && IDX < i_pos) begin
                    n_entry = '0;   // zero-fill the gap past the old end
                end
            end
            CELL_WRITE: begin
                if (IDX == i_pos) begin
                    n_entry = i_value;
                end
            end
            CELL_REMOVE: begin
                if (IDX >= i_pos && IDX < i_len) begin
                    n_entry = (IDX == w_last) ? '0 : i_right;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

### design/pls_read_sel.sv
// Two-level registered select of one addressable entry for reads.
module pls_read_sel
    import pls_pkg::*;
#(
    parameter int N          = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [POS_BITS-1:0]   i_pos,
    input  logic [VALUE_BITS-1:0] i_entries [N],
    output logic [VALUE_BITS-1:0] o_word
);

    localparam int GROUPS = (N + 7) / 8;

    logic [VALUE_BITS-1:0] r_grp [GROUPS];
    logic [VALUE_BITS-1:0] n_grp [GROUPS];

    // First level: gate each entry by its address match, OR in groups of eight
    always_comb begin
        int idx;
        for (int g = 0; g < GROUPS; g++) begin
            n_grp[g] = '0;
            for (int k = 0; k < 8; k++) begin
                idx = g * 8 + k;
                if (idx < N) begin
                    if (i_pos == POS_BITS'(idx)) begin
                        n_grp[g] = n_grp[g] | i_entries[idx];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_grp <= n_grp;
        end
    end

    // Second level: at most eight groups
    always_comb begin
        o_word = '0;
        for (int g = 0; g < GROUPS; g++) begin
            o_word = o_word | r_grp[g];
        end
    end

endmodule

### design/positional_list_store.sv
// Top level of the positional list store: command sequencer, cell row and read select.
//
//  Channel | Direction | Handshake                     | Payload
//  --------+-----------+-------------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_ready       | i_in_data  (t_in_item)
//  out     | output    | o_out_valid / i_out_ready     | o_out_data (t_out_item)
//
//  After its transfer a command is decoded and shifted through the cells in the execute
//  state; the second level of the read select then feeds the output register in done.
//  The three-state sequencer takes no new command before the last result is registered;
//  the next command is taken in the cycle after the result is registered, even while it waits.
//  Reset (synchronous, active low) empties the list and clears every cell to zero.
//  A stalled output holds the sequencer in its last state until the slot frees.
module positional_list_store
    import pls_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int LEN_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = ((LEN_W > POS_BITS) ? LEN_W : POS_BITS) + 1;
    // Only the first 64 slots can be named by a position
    localparam int RD_N   = (CAPACITY < (1 << POS_BITS)) ? CAPACITY : (1 << POS_BITS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } t_state;

    t_state           r_state;
    t_in_item         r_item;
    logic [LEN_W-1:0] r_len;
    t_status          r_status;
    logic             r_read_ok;
    logic             r_out_valid;
    t_out_item        r_out;

    // Decode of the held command, against the current length
    t_status               n_status;
    t_cell_op              n_cell_op;
    logic [CMP_W-1:0]      n_cell_pos;
    logic [CMP_W-1:0]      n_len;
    logic                  n_read_ok;
    logic [CMP_W-1:0]      w_pos;
    logic [CMP_W-1:0]      w_len;
    logic [CMP_W-1:0]      w_cap;
    logic [CMP_W-1:0]      w_eff;
    logic [VALUE_BITS-1:0] w_value;
    t_cell_op              w_op;
    logic                  w_in_xfer;
    logic                  w_out_load;

    logic [VALUE_BITS-1:0] w_entry  [CAPACITY];
    logic [VALUE_BITS-1:0] w_rd_src [RD_N];
    logic [VALUE_BITS-1:0] w_rd_word;
    logic signed [63:0]    w_rd_ext;
    logic signed [63:0]    w_in_ext;

    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // Fit the incoming word into the stored width, two's complement
    assign w_in_ext = 64'(r_item.value);
    assign w_value  = w_in_ext[VALUE_BITS-1:0];

    assign w_pos = CMP_W'(r_item.position);
    assign w_len = CMP_W'(r_len);
    assign w_cap = CMP_W'(CAPACITY);

    always_comb begin
        n_status   = ST_DONE;
        n_cell_op  = CELL_HOLD;
        n_cell_pos = w_pos;
        n_len      = w_len;
        n_read_ok  = 1'b0;
        w_eff      = w_pos;
        case (r_item.command)
            CMD_INSERT: begin
                w_eff = r_item.at_end ? w_len : w_pos;
                if (w_len >= w_cap) begin
                    n_status = ST_FULL;
                end else if (w_eff >= w_cap) begin
                    n_status = ST_BAD_POS;
                end else begin
                    n_cell_op  = CELL_INSERT;
                    n_cell_pos = w_eff;
                    n_len      = (w_eff > w_len) ? w_eff + CMP_W'(1) : w_len + CMP_W'(1);
                end
            end
            CMD_MODIFY: begin
                if (w_pos >= w_cap) begin
                    n_status = ST_BAD_POS;
                end else begin
                    n_cell_op = CELL_WRITE;
                end
            end
            CMD_REMOVE: begin
                w_eff = r_item.at_end ? w_len - CMP_W'(1) : w_pos;
                if (w_len == '0 || w_eff >= w_len) begin
                    n_status = ST_BAD_POS;
                end else begin
                    n_cell_op  = CELL_REMOVE;
                    n_cell_pos = w_eff;
                    n_len      = w_len - CMP_W'(1);
                end
            end
            CMD_READ: begin
                if (w_pos >= w_len) begin
                    n_status = ST_BAD_POS;
                end else begin
                    n_read_ok = 1'b1;
                end
            end
            default: begin
                n_status = ST_DONE;
            end
        endcase
    end

    // Cells act only in the execute cycle
    assign w_op = (r_state == S_EXEC) ? n_cell_op : CELL_HOLD;

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic [VALUE_BITS-1:0] w_left;
        logic [VALUE_BITS-1:0] w_right;

        if (gi == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_entry[gi-1];
        end

        if (gi == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_entry[gi+1];
        end

        pls_cell #(
            .INDEX      (gi),
            .LEN_W      (LEN_W),
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_op    (w_op),
            .i_pos   (n_cell_pos[LEN_W-1:0]),
            .i_len   (r_len),
            .i_value (w_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_entry (w_entry[gi])
        );
    end

    for (genvar gr = 0; gr < RD_N; gr++) begin : g_rd_src
        assign w_rd_src[gr] = w_entry[gr];
    end

    // Reads change nothing, so the first level samples in the execute cycle
    pls_read_sel #(
        .N          (RD_N),
        .VALUE_BITS (VALUE_BITS)
    ) u_read_sel (
        .i_clk     (i_clk),
        .i_en      (r_state == S_EXEC),
        .i_pos     (r_item.position),
        .i_entries (w_rd_src),
        .o_word    (w_rd_word)
    );

    assign w_rd_ext = 64'($signed(w_rd_word));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Load a new result, or drop the old one once it has been taken
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_len   <= n_len[LEN_W-1:0];
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // Hold until the output slot is free
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_item <= i_in_data;
        end
        if (r_state == S_EXEC) begin
            r_status  <= n_status;
            r_read_ok <= n_read_ok;
        end
        if (w_out_load) begin
            r_out.status      <= r_status;
            r_out.read_value  <= r_read_ok ? w_rd_ext[WORD_BITS-1:0] : '0;
            r_out.list_length <= LEN_OUT_BITS'(r_len);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Length never runs past the row of cells
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(CAPACITY))
        else $error("list length above capacity");

    // A full report comes only from a full list
    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == ST_FULL) |->
            o_out_data.list_length == LEN_OUT_BITS'(CAPACITY))
        else $error("full status with list not full");

    // Failed commands return a zero word
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != ST_DONE) |-> o_out_data.read_value == '0)
        else $error("nonzero read value on failed command");

    // An accepted command goes straight to execute
    a_xfer_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> r_state == S_EXEC)
        else $error("accepted command not executed");

    // The length only moves in the execute cycle
    a_len_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) != S_EXEC && $past(i_rst_n)) |-> $stable(r_len))
        else $error("length changed outside execute");

endmodule
